// ----- design/stsid_pkg.sv -----
package stsid_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 16;

    localparam int KEY_W    = 32;
    localparam int RANGE_W  = 4;
    localparam int CAP_W    = 5;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 4;
    localparam int TOTAL_W  = 5;
    localparam int ACTION_W = 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SEARCH = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_NOP    = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE      = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_SHIFT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic shift;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic step_done;
        logic need_shift;
        logic out_busy;
    } sts_t;

endpackage

// ----- design/stsid_ctrl.sv -----
module stsid_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  stsid_pkg::sts_t sts,
    output stsid_pkg::cmd_t cmd
);
    import stsid_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_STEP;
            end
            ST_STEP: begin
                if (sts.step_done) state_next = sts.need_shift ? ST_SHIFT : ST_EMIT;
            end
            ST_SHIFT: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!sts.out_busy) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_STEP: begin
                cmd.step = 1'b1;
            end
            ST_SHIFT: begin
                cmd.shift = 1'b1;
            end
            ST_EMIT: begin
                cmd.emit = !sts.out_busy;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- design/stsid_dp.sv -----
module stsid_dp #(
    parameter int TABLE_DEPTH = stsid_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [stsid_pkg::CAP_W-1:0]       cfg_wr_data,
    input  logic [stsid_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [stsid_pkg::ACTION_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [stsid_pkg::M_TDATA_W-1:0]   m_tdata,
    input  stsid_pkg::cmd_t                   cmd,
    output stsid_pkg::sts_t                   sts
);
    import stsid_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int PW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic signed [KEY_W-1:0] entries_reg [TABLE_DEPTH];
    logic signed [KEY_W-1:0] up_src [TABLE_DEPTH];
    logic signed [KEY_W-1:0] dn_src [TABLE_DEPTH];

    logic [CNT_W-1:0]        count_reg;
    logic [CAP_W-1:0]        cap_reg;
    action_t                 act_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic                    full_reg;
    logic [PW-1:0]           lo_reg, end_reg, idx_reg;
    status_t                 res_status_reg;

    logic                    m_tvalid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;

    logic [PW-1:0]           cnt, cap_eff, sh_end, lo_init, end_init;
    logic [PW:0]             mid_sum;
    logic [PW-1:0]           mid;
    logic signed [KEY_W-1:0] mid_val;
    logic                    empty_range, hit, is_insert;
    action_t                 s_act;
    logic signed [KEY_W-1:0] s_key;
    logic [RANGE_W-1:0]      s_low, s_high;

    assign s_act  = action_t'(s_tuser);
    assign s_key  = s_tdata[KEY_W-1:0];
    assign s_low  = s_tdata[KEY_W +: RANGE_W];
    assign s_high = s_tdata[KEY_W+RANGE_W +: RANGE_W];

    assign cnt     = PW'(count_reg);
    assign cap_eff = (PW'(cap_reg) < PW'(TABLE_DEPTH)) ? PW'(cap_reg) : PW'(TABLE_DEPTH);
    assign sh_end  = PW'(s_high) + PW'(1);

    always_comb begin
        lo_init  = '0;
        end_init = cnt;
        if (s_act == ACT_SEARCH) begin
            lo_init  = PW'(s_low);
            end_init = (sh_end < cnt) ? sh_end : cnt;
        end
    end

    // midpoint of [lo, end-1], rounded down
    assign mid_sum     = {1'b0, lo_reg} + {1'b0, end_reg} - (PW + 1)'(1);
    assign mid         = mid_sum[PW:1];
    assign mid_val     = entries_reg[mid[IDX_W-1:0]];
    assign empty_range = !(lo_reg < end_reg);
    assign hit         = (mid_val == key_reg);
    assign is_insert   = (act_reg == ACT_INSERT);

    always_comb begin
        sts.out_busy   = m_tvalid_reg && !m_tready;
        sts.step_done  = 1'b0;
        sts.need_shift = 1'b0;
        priority if (act_reg == ACT_NOP) begin
            sts.step_done = 1'b1;
        end else if (is_insert && full_reg) begin
            sts.step_done = 1'b1;
        end else if (empty_range) begin
            sts.step_done  = 1'b1;
            sts.need_shift = is_insert;
        end else if (!is_insert && hit) begin
            sts.step_done  = 1'b1;
            sts.need_shift = (act_reg == ACT_DELETE);
        end else begin
            sts.step_done = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg  <= s_act;
            key_reg  <= s_key;
            full_reg <= !(cnt < cap_eff);
            lo_reg   <= lo_init;
            end_reg  <= end_init;
        end else if (cmd.step) begin
            if (sts.step_done) begin
                if (act_reg == ACT_NOP) begin
                    res_status_reg <= STAT_DONE;
                    idx_reg        <= '0;
                end else if (is_insert && full_reg) begin
                    res_status_reg <= STAT_FULL;
                    idx_reg        <= '0;
                end else if (empty_range && is_insert) begin
                    res_status_reg <= STAT_DONE;
                    idx_reg        <= lo_reg;
                end else if (empty_range) begin
                    res_status_reg <= STAT_NOT_FOUND;
                    idx_reg        <= '0;
                end else begin
                    res_status_reg <= STAT_DONE;
                    idx_reg        <= mid;
                end
            end else if (mid_val > key_reg) begin
                end_reg <= mid;
            end else begin
                lo_reg <= mid + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.shift) begin
            if (is_insert) begin
                count_reg <= count_reg + CNT_W'(1);
            end else begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign up_src[i] = key_reg;
        end else begin : g_up
            assign up_src[i] = entries_reg[i-1];
        end
        if (i == TABLE_DEPTH - 1) begin : g_last
            assign dn_src[i] = key_reg;
        end else begin : g_dn
            assign dn_src[i] = entries_reg[i+1];
        end

        always_ff @(posedge aclk) begin
            if (cmd.shift) begin
                if (is_insert) begin
                    if (PW'(i) == idx_reg) begin
                        entries_reg[i] <= key_reg;
                    end else if (PW'(i) > idx_reg && PW'(i) <= cnt) begin
                        entries_reg[i] <= up_src[i];
                    end
                end else if (PW'(i) >= idx_reg && (PW'(i) + PW'(1)) < cnt) begin
                    entries_reg[i] <= dn_src[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_tdata_reg <= M_TDATA_W'({TOTAL_W'(count_reg), INDEX_W'(idx_reg),
                                       res_status_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- design/sorted_table_search_insert_delete.sv -----
// Sorted table of signed 32-bit keys held in a row of shift cells, with a fill count.
// s_tuser selects the operation (0 search, 1 insert, 2 delete, 3 no-op); s_tdata
// carries key, search_low and search_high. Search clamps its range to the filled
// entries; insert places the key after equal entries and is refused with status 2
// once the count reaches min(capacity_limit, TABLE_DEPTH); delete removes the entry
// a full-table binary search finds. One result word per input word. Each word is loaded,
// then takes binary-search steps (one table read and one 32-bit compare per cycle), then a
// shift for a successful insert or delete, then an output step. One word is in work at
// a time; the output register lets the next word be accepted while a result waits.
// capacity_limit may be written only while the block is idle.
module sorted_table_search_insert_delete #(
    parameter int TABLE_DEPTH = stsid_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [stsid_pkg::CAP_W-1:0]      cfg_wr_data,   // capacity_limit
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [stsid_pkg::S_TDATA_W-1:0]  s_tdata,       // key, search_low, search_high
    input  logic [stsid_pkg::ACTION_W-1:0]   s_tuser,       // action
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [stsid_pkg::M_TDATA_W-1:0]  m_tdata        // status, result_index, entry_total
);
    import stsid_pkg::*;

    cmd_t cmd;
    sts_t sts;

    stsid_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    stsid_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
    import stsid_pkg::*;

    localparam int TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        status_t            status;
        logic [INDEX_W-1:0] slot;
        logic [TOTAL_W-1:0] total;
    } table_reply_t;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CAP_W-1:0]     cfg_wr_data = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata     = '0;   // key, search_low, search_high
    logic [ACTION_W-1:0]  s_tuser     = '0;   // action
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;            // status, result_index, entry_total

    // shadow table kept in step with accepted words
    logic signed [KEY_W-1:0] key_table [TABLE_DEPTH];
    int fill;
    int cap_limit;

    table_reply_t pending_replies [$];

    int   src_idle_pct;
    int   sink_stall_pct;
    logic hold_go = 1'b0;
    int   hold_left;
    int   cycles;
    int   err_count;
    int   words_sent;
    int   caps_tried;
    int   n_done;
    int   n_missing;
    int   n_full;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    sorted_table_search_insert_delete #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    function automatic int find_entry(int lo, int hi, logic signed [KEY_W-1:0] key);
        int mid;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (key_table[mid] == key)
                return mid;
            if (key_table[mid] > key)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return -1;
    endfunction

    function automatic table_reply_t apply_table_op(action_t act,
                                                    logic signed [KEY_W-1:0] key,
                                                    logic [RANGE_W-1:0] lo,
                                                    logic [RANGE_W-1:0] hi);
        table_reply_t r;
        int found;
        int top;
        int pos;
        int eff;
        r.status = STAT_DONE;
        r.slot   = '0;
        found    = -1;
        case (act)
            ACT_SEARCH: begin
                if (fill > 0) begin
                    top   = (int'(hi) > fill - 1) ? fill - 1 : int'(hi);
                    found = find_entry(int'(lo), top, key);
                end
                if (found < 0)
                    r.status = STAT_NOT_FOUND;
                else
                    r.slot = found[INDEX_W-1:0];
            end
            ACT_INSERT: begin
                eff = (cap_limit > TABLE_DEPTH) ? TABLE_DEPTH : cap_limit;
                if (fill >= eff) begin
                    r.status = STAT_FULL;
                end else begin
                    pos = fill;
                    while (pos > 0 && key_table[pos-1] > key) begin
                        key_table[pos] = key_table[pos-1];
                        pos--;
                    end
                    key_table[pos] = key;
                    fill++;
                    r.slot = pos[INDEX_W-1:0];
                end
            end
            ACT_DELETE: begin
                if (fill > 0)
                    found = find_entry(0, fill - 1, key);
                if (found < 0) begin
                    r.status = STAT_NOT_FOUND;
                end else begin
                    for (int i = found; i + 1 < fill; i++)
                        key_table[i] = key_table[i+1];
                    fill--;
                    r.slot = found[INDEX_W-1:0];
                end
            end
            default: ;
        endcase
        r.total = fill[TOTAL_W-1:0];
        return r;
    endfunction

    // mostly keys already stored or near each other, so searches and deletes hit
    function automatic logic signed [KEY_W-1:0] pick_key(int hit_pct);
        int r;
        r = $urandom_range(99);
        if (fill > 0 && r < hit_pct)
            return key_table[$urandom_range(fill - 1)];
        r = $urandom_range(9);
        if (r < 4)
            return int'($urandom_range(16)) - 8;
        if (r < 6) begin
            case ($urandom_range(3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'hFFFF_FFFF;
                default: return 32'h0000_0000;
            endcase
        end
        return $urandom;
    endfunction

    task automatic send_word(action_t act, logic signed [KEY_W-1:0] key,
                             logic [RANGE_W-1:0] lo, logic [RANGE_W-1:0] hi);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {hi, lo, key};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pending_replies.push_back(apply_table_op(act, key, lo, hi));
        words_sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        wait_idle();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cap_limit = int'(value);
        caps_tried++;
    endtask

    // alternates between filling toward the limit and draining toward empty
    task automatic run_random(int count, int src_pct, int sink_pct);
        logic                    filling;
        action_t                 act;
        logic signed [KEY_W-1:0] key;
        logic [RANGE_W-1:0]      lo;
        logic [RANGE_W-1:0]      hi;
        int                      eff;
        int                      r;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        filling        = 1'b1;
        repeat (count) begin
            eff = (cap_limit > TABLE_DEPTH) ? TABLE_DEPTH : cap_limit;
            if (fill == 0)
                filling = 1'b1;
            else if (fill >= eff || $urandom_range(99) < 3)
                filling = 1'b0;
            r = $urandom_range(99);
            if (r < 5)
                act = ACT_NOP;
            else if (r < 30)
                act = ACT_SEARCH;
            else if (r < 80)
                act = filling ? ACT_INSERT : ACT_DELETE;
            else
                act = filling ? ACT_DELETE : ACT_INSERT;
            key = pick_key((act == ACT_INSERT) ? 30 : 70);
            if ($urandom_range(9) < 3) begin
                lo = '0;
                hi = '1;
            end else begin
                lo = RANGE_W'($urandom_range(15));
                hi = RANGE_W'($urandom_range(15));
            end
            send_word(act, key, lo, hi);
        end
    endtask

    task automatic test_directed();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        send_word(ACT_SEARCH, 32'sd0, 4'd0, 4'd15);         // empty table
        send_word(ACT_DELETE, 32'sd0, 4'd0, 4'd0);
        send_word(ACT_NOP, 32'hFFFF_FFFF, 4'hF, 4'hF);
        send_word(ACT_INSERT, 32'h7FFF_FFFF, 4'd0, 4'd0);
        send_word(ACT_INSERT, 32'h8000_0000, 4'd0, 4'd0);
        send_word(ACT_INSERT, 32'sd5, 4'd0, 4'd0);
        send_word(ACT_INSERT, 32'sd5, 4'd0, 4'd0);
        send_word(ACT_INSERT, 32'sd5, 4'd0, 4'd0);
        send_word(ACT_INSERT, -32'sd1, 4'd0, 4'd0);
        send_word(ACT_SEARCH, 32'sd5, 4'd0, 4'd15);         // high past fill, duplicates
        send_word(ACT_SEARCH, 32'sd5, 4'd15, 4'd15);        // low past fill
        send_word(ACT_SEARCH, 32'sd5, 4'd3, 4'd0);          // low above high
        send_word(ACT_SEARCH, 32'h8000_0000, 4'd0, 4'd0);
        send_word(ACT_SEARCH, 32'h7FFF_FFFF, 4'd3, 4'd15);
        send_word(ACT_SEARCH, 32'sd6, 4'd0, 4'd15);
        send_word(ACT_DELETE, 32'sd5, 4'd0, 4'd0);
        send_word(ACT_DELETE, 32'sd5, 4'd0, 4'd0);
        send_word(ACT_DELETE, 32'sd99, 4'd0, 4'd0);
        send_word(ACT_DELETE, 32'h7FFF_FFFF, 4'd0, 4'd0);
        send_word(ACT_DELETE, 32'h8000_0000, 4'd0, 4'd0);
        send_word(ACT_NOP, 32'sd0, 4'd0, 4'd0);
    endtask

    task automatic test_capacity_extremes();
        write_capacity(5'd31);          // above depth, table can fill to 16
        run_random(200, 0, 0);
        write_capacity(5'd0);           // every insert refused
        run_random(60, 73, 0);
    endtask

    task automatic test_idle_phases();
        write_capacity(5'd1);
        run_random(100, 0, 73);
        write_capacity(5'd7);
        run_random(200, 26, 26);
        write_capacity(5'd16);
        run_random(300, 73, 0);
        write_capacity(5'd12);
        run_random(300, 26, 26);
    endtask

    task automatic test_backpressure();
        wait_idle();
        hold_go <= 1'b1;
        @(posedge aclk);
        hold_go <= 1'b0;
        run_random(40, 0, 0);
    endtask

    always @(posedge aclk) begin
        if (hold_go)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge aclk) begin
        if (hold_left != 0)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin : check_replies
        table_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            case (m_tdata[STATUS_W-1:0])
                STAT_DONE:      n_done++;
                STAT_NOT_FOUND: n_missing++;
                default:        n_full++;
            endcase
            if (pending_replies.size() == 0) begin
                $error("reply word %h with none pending", m_tdata);
                err_count++;
            end else begin
                want = pending_replies.pop_front();
                if (m_tdata[STATUS_W-1:0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status,
                           m_tdata[STATUS_W-1:0]);
                    err_count++;
                end
                if (m_tdata[STATUS_W +: INDEX_W] !== want.slot) begin
                    $error("result_index: expected %0d, got %0d", want.slot,
                           m_tdata[STATUS_W +: INDEX_W]);
                    err_count++;
                end
                if (m_tdata[STATUS_W+INDEX_W +: TOTAL_W] !== want.total) begin
                    $error("entry_total: expected %0d, got %0d", want.total,
                           m_tdata[STATUS_W+INDEX_W +: TOTAL_W]);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d replies pending", cycles,
                   pending_replies.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        cap_limit = int'(CAP_RESET);
        fill      = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_capacity_extremes();
        test_idle_phases();
        test_backpressure();
        wait_idle();
        repeat (20) @(posedge aclk);
        $display("Ran %0d words over %0d capacity settings, four idle mixes and a long hold",
                 words_sent, caps_tried);
        $display("Replies: %0d done, %0d not found, %0d refused as full",
                 n_done, n_missing, n_full);
        if (err_count == 0 && pending_replies.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
design/stsid_pkg.sv
design/stsid_ctrl.sv
design/stsid_dp.sv
design/sorted_table_search_insert_delete.sv
verif/tb_top.sv
